FILE: rtl/b2da_pkg.sv
package b2da_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned PLACE_W     = 4;
	localparam int unsigned CHAR_W      = 6;
	localparam int unsigned BOUND_W     = 36;
	localparam int unsigned NUM_PLACES  = 10;
	localparam int unsigned QUEUE_DEPTH = 2;

	// place index of the units digit, the last place of every run
	localparam logic [PLACE_W-1:0] UNITS_PLACE = 4'd9;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'h30;

	// decimal weight of a place, most significant place first
	function automatic logic [VALUE_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
		logic [VALUE_W-1:0] w;
		case (place)
			4'd0:    w = 32'd1000000000;
			4'd1:    w = 32'd100000000;
			4'd2:    w = 32'd10000000;
			4'd3:    w = 32'd1000000;
			4'd4:    w = 32'd100000;
			4'd5:    w = 32'd10000;
			4'd6:    w = 32'd1000;
			4'd7:    w = 32'd100;
			4'd8:    w = 32'd10;
			4'd9:    w = 32'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

	// one queued request: the value and the place of its leading digit
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [PLACE_W-1:0] place;
	} b2da_item_t;

	// queue head as seen by the digit sequencer
	typedef struct packed {
		logic       valid;
		b2da_item_t item;
	} b2da_head_t;

endpackage

FILE: rtl/binary_to_decimal_ascii.sv
// Unsigned 32-bit binary to decimal ASCII converter.
//
// Slave channel (s_*): one request per value. Master channel (m_*): one
// request per character, most significant digit first, leading zeros
// dropped; a zero value gives a single '0'. m_tlast marks the units digit.
//
// Classified values wait in a small queue between the input side and the
// digit sequencer, so the input keeps taking values while characters are
// still being sent. The sequencer produces one digit per cycle unless
// m_tready stalls it, by a parallel compare against the nine multiples of
// the place weight; a value gives 1 to 10 characters, the next loads at
// its units digit. A value passes queue, sequencer and output register.
//
// A stall on m_tready holds the current character and freezes the
// sequencer; the queue then fills and s_tready drops. Reset clears the
// queue, the sequencer and the output register; nothing else is kept.
module binary_to_decimal_ascii import b2da_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] digit_char, [7:6] zero
	output logic        m_tlast
);

	b2da_head_t        head;
	logic              pop;
	logic [CHAR_W-1:0] digit_char;

	b2da_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.value   (s_tdata),
		.head    (head),
		.pop     (pop)
	);

	b2da_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.digit_char(digit_char),
		.last      (m_tlast)
	);

	// pad the character to a whole byte
	assign m_tdata = {2'b00, digit_char};

endmodule

FILE: rtl/b2da_front.sv
module b2da_front import b2da_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] value,
	output b2da_head_t         head,
	input  logic               pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	b2da_item_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [PLACE_W-1:0] lead_place;
	logic               push;

	// find the leading digit: count the weights above the value
	always_comb begin
		lead_place = '0;
		for (int i = 0; i < NUM_PLACES - 1; i++) begin
			if (value < place_weight(PLACE_W'(i)))
				lead_place = lead_place + 1'b1;
		end
	end

	assign s_tready = (count_q != CNT_FULL);
	assign push     = s_tvalid && s_tready;

	// hold classified requests until the sequencer takes them
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].value <= value;
			mem_q[wr_ptr_q].place <= lead_place;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	// the sequencer only takes a request that is there
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count out of range");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

FILE: rtl/b2da_back.sv
module b2da_back import b2da_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  b2da_head_t        head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] digit_char,
	output logic              last
);

	logic               busy_q;
	logic [VALUE_W-1:0] rest_q;
	logic [PLACE_W-1:0] place_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	logic [VALUE_W-1:0] weight;
	logic [BOUND_W-1:0] bound [NUM_PLACES];
	logic [3:0]         digit;
	logic [BOUND_W-1:0] sub;
	logic               out_free;
	logic               step;
	logic               last_step;
	logic               load;

	// digit of the current place: compare against all nine multiples
	always_comb begin
		weight   = place_weight(place_q);
		bound[0] = '0;
		digit    = '0;
		for (int k = 1; k < NUM_PLACES; k++) begin
			bound[k] = BOUND_W'(weight) * BOUND_W'(k);
			if ({{(BOUND_W - VALUE_W){1'b0}}, rest_q} >= bound[k])
				digit = digit + 4'd1;
		end
		sub = bound[digit];
	end

	assign out_free  = !out_valid_q || m_tready;
	assign step      = busy_q && out_free;
	assign last_step = step && (place_q == UNITS_PLACE);
	assign load      = head.valid && (!busy_q || last_step);
	assign pop       = load;

	// advance one place per cycle while the output register has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				busy_q <= 1'b1;
			else if (last_step)
				busy_q <= 1'b0;
			if (step)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rest_q  <= head.item.value;
			place_q <= head.item.place;
		end else if (step) begin
			rest_q  <= rest_q - sub[VALUE_W-1:0];
			place_q <= place_q + 1'b1;
		end
		if (step) begin
			out_char_q <= ASCII_ZERO + {2'b00, digit};
			out_last_q <= (place_q == UNITS_PLACE);
		end
	end

	assign m_tvalid   = out_valid_q;
	assign digit_char = out_char_q;
	assign last       = out_last_q;

	a_place_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> place_q <= UNITS_PLACE)
		else $error("place index past the units digit");

	// the remainder never reaches ten units of the current place
	a_rest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> {{(BOUND_W - VALUE_W){1'b0}}, rest_q} <
			BOUND_W'(place_weight(place_q)) * BOUND_W'(10))
		else $error("remainder too large for its place");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_char_q >= 6'd48 && out_char_q <= 6'd57))
		else $error("character is not a decimal digit");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(last_step && !load) |=> !busy_q)
		else $error("sequencer stayed busy after the units digit");

endmodule
